// ===== design/wpec_pkg.sv =====
// Shared types and constants of the windowed presence event coder.
package wpec_pkg;

	localparam logic [1:0] CODE_ABSENT  = 2'd0;
	localparam logic [1:0] CODE_ALERT   = 2'd1;
	localparam logic [1:0] CODE_TRANSIT = 2'd2;

	localparam logic [1:0] REG_NUM_CLASSES   = 2'd0;
	localparam logic [1:0] REG_WINDOW_LENGTH = 2'd1;
	localparam logic [1:0] REG_THRESHOLD     = 2'd2;
	localparam logic [1:0] REG_SLIDE_MODE    = 2'd3;

	localparam int RING_AW = 6;

	typedef struct packed {
		logic [6:0]         fill;
		logic [RING_AW-1:0] head;
		logic [6:0]         det_cnt;
		logic [1:0]         code;
		logic [6:0]         held;
		logic [6:0]         tal_abs;
		logic [6:0]         tal_alr;
		logic [6:0]         tal_trn;
	} wpec_state_t;

	typedef struct packed {
		logic       det;
		logic [1:0] code;
	} wpec_ring_t;

endpackage

// ===== design/wpec_slot_alu.sv =====
// Shared slot update unit: window step, threshold compare and tally update.
module wpec_slot_alu import wpec_pkg::*; (
	input  wpec_state_t        st,
	input  wpec_ring_t         oldest,
	input  logic               det,
	input  logic [6:0]         len,
	input  logic [8:0]         thr,
	input  logic               slide,
	output wpec_state_t        nxt,
	output wpec_ring_t         ring_wr,
	output logic [RING_AW-1:0] ring_off
);

	logic [6:0]  f;
	logic        full;
	logic [6:0]  hits;
	logic [15:0] prod;
	logic        above;
	logic [1:0]  code;
	logic        drop;

	function automatic logic [6:0] tally(input logic [6:0] t, input logic [1:0] c,
		input logic [1:0] k, input logic sub, input logic [1:0] oc);
		logic [6:0] r;
		r = t + {6'd0, (c == k)};
		r = r - {6'd0, (sub && (oc == k))};
		return r;
	endfunction

	always_comb begin
		f     = (st.fill >= len) ? (len - 7'd1) : st.fill;
		full  = ({1'b0, f} + 8'd1) >= {1'b0, len};
		hits  = st.det_cnt + {6'd0, det};
		prod  = {7'd0, thr} * {9'd0, len};
		above = {1'b0, hits, 8'd0} >= prod;
		if (full && above)
			code = det ? CODE_ALERT : CODE_TRANSIT;
		else
			code = det ? CODE_TRANSIT : CODE_ABSENT;
		ring_off     = st.head + f[RING_AW-1:0];
		ring_wr.det  = det;
		ring_wr.code = code;
		drop = full && slide && (f != 7'd0);

		nxt      = st;
		nxt.code = code;
		if (full) begin
			nxt.held = hits;
			if (drop) begin
				nxt.fill    = f;
				nxt.head    = st.head + RING_AW'(1);
				nxt.det_cnt = hits - {6'd0, oldest.det};
				nxt.tal_abs = tally(st.tal_abs, code, CODE_ABSENT, 1'b1, oldest.code);
				nxt.tal_alr = tally(st.tal_alr, code, CODE_ALERT, 1'b1, oldest.code);
				nxt.tal_trn = tally(st.tal_trn, code, CODE_TRANSIT, 1'b1, oldest.code);
			end else begin
				nxt.fill    = 7'd0;
				nxt.det_cnt = 7'd0;
				nxt.tal_abs = 7'd0;
				nxt.tal_alr = 7'd0;
				nxt.tal_trn = 7'd0;
			end
		end else begin
			nxt.fill    = f + 7'd1;
			nxt.det_cnt = hits;
			nxt.tal_abs = tally(st.tal_abs, code, CODE_ABSENT, 1'b0, oldest.code);
			nxt.tal_alr = tally(st.tal_alr, code, CODE_ALERT, 1'b0, oldest.code);
			nxt.tal_trn = tally(st.tal_trn, code, CODE_TRANSIT, 1'b0, oldest.code);
		end
	end

endmodule

// ===== design/wpec_state_mem.sv =====
// Per source and slot state memory with valid bits; invalid entries read as reset state.
module wpec_state_mem import wpec_pkg::*; #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          clear,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output wpec_state_t   rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  wpec_state_t   wr_data
);

	wpec_state_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	wpec_state_t raw_q;
	logic hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (clear)
				valid_q <= '0;
			else if (wr_en)
				valid_q[wr_addr] <= 1'b1;
			if (rd_en)
				hit_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			raw_q <= mem[rd_addr];
	end

	assign rd_data = hit_q ? raw_q : '0;

endmodule

// ===== design/windowed_presence_event_coder.sv =====
// Top level: configuration registers, slot sequencer, code ring memory and output register.
// Each slot of a frame passes the states ST_RD (state read), ST_RING (code ring read) and
//   ST_EXEC (update and output register); ST_EXEC waits while the output is not taken.
// One frame at a time: a new frame is taken only in idle, after its last slot's result is registered.
// An out-of-range source or a zero slot count is accepted and gives no result.
// Reset clears registers to their defaults and all per-slot state through valid bits at once.
module windowed_presence_event_coder import wpec_pkg::*; #(
	parameter int MAX_CLASSES = 8,
	parameter int MAX_WINDOW  = 64,
	parameter int NUM_SOURCES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // source_index[3:0], detected_mask[11:4]
	input  logic        s_tuser,  // inferred
	output logic        m_tvalid,
	input  logic        m_tready,
	// slot[2:0], evt_code[4:3], window_hits[11:5], absent_tally[18:12],
	// alert_tally[25:19], transit_tally[32:26]
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int SLOTS = NUM_SOURCES * MAX_CLASSES;
	localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_RING = 2'd2;
	localparam logic [1:0] ST_EXEC = 2'd3;

	logic [3:0] num_classes_q;
	logic [6:0] window_length_q;
	logic [8:0] threshold_q;
	logic       slide_q;

	logic [1:0]  st_q;
	logic [3:0]  src_q;
	logic        upd_q;
	logic [7:0]  mask_q;
	logic [2:0]  slot_q;
	logic [15:0] seen_q;
	logic        out_valid_q;
	logic [39:0] out_data_q;
	logic        out_last_q;

	logic [3:0] n_eff;
	logic [6:0] len_eff;
	logic [6:0] len_new;
	logic       cfg_wr;
	logic       clear;
	logic       in_xfer;
	logic       src_ok;
	logic [IW-1:0] idx;
	logic       out_free;
	logic       last;

	wpec_state_t st_rd;
	wpec_state_t st_nxt;
	wpec_state_t st_out;
	wpec_ring_t  ring_q;
	wpec_ring_t  ring_wr;
	logic [RING_AW-1:0] ring_off;
	wpec_ring_t  ring_mem [SLOTS * (2 ** RING_AW)];

	function automatic logic [6:0] eff_len(input logic [6:0] raw);
		if (raw == 7'd0)
			return 7'd1;
		else if (raw > 7'(MAX_WINDOW))
			return 7'(MAX_WINDOW);
		else
			return raw;
	endfunction

	always_comb begin
		n_eff = num_classes_q;
		if (n_eff > 4'(MAX_CLASSES))
			n_eff = 4'(MAX_CLASSES);
		if (n_eff > 4'd8)
			n_eff = 4'd8;
	end

	assign len_eff  = eff_len(window_length_q);
	assign len_new  = eff_len(pwdata[6:0]);
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign s_tready = (st_q == ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign src_ok   = {28'd0, s_tdata[3:0]} < 32'(NUM_SOURCES);
	assign idx      = IW'(({28'd0, src_q} * 32'(MAX_CLASSES)) + {29'd0, slot_q});
	assign out_free = !out_valid_q || m_tready;
	assign last     = ({1'b0, slot_q} + 4'd1) == n_eff;

	always_comb begin
		clear = 1'b0;
		if (cfg_wr) begin
			case (paddr[3:2])
				REG_NUM_CLASSES:   clear = 1'b1;
				REG_WINDOW_LENGTH: clear = (len_new != len_eff);
				REG_SLIDE_MODE:    clear = 1'b1;
				default:           clear = 1'b0;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NUM_CLASSES:   prdata = {28'd0, num_classes_q};
			REG_WINDOW_LENGTH: prdata = {25'd0, window_length_q};
			REG_THRESHOLD:     prdata = {23'd0, threshold_q};
			REG_SLIDE_MODE:    prdata = {31'd0, slide_q};
			default:           prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q   <= 4'd0;
			window_length_q <= 7'd10;
			threshold_q     <= 9'd128;
			slide_q         <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_NUM_CLASSES:   num_classes_q   <= pwdata[3:0];
				REG_WINDOW_LENGTH: window_length_q <= pwdata[6:0];
				REG_THRESHOLD:     threshold_q     <= pwdata[8:0];
				REG_SLIDE_MODE:    slide_q         <= pwdata[0];
				default:           ;
			endcase
		end
	end

	wpec_state_mem #(.DEPTH(SLOTS), .AW(IW)) u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (clear),
		.rd_en   (st_q == ST_RD),
		.rd_addr (idx),
		.rd_data (st_rd),
		.wr_en   ((st_q == ST_EXEC) && out_free && upd_q),
		.wr_addr (idx),
		.wr_data (st_nxt)
	);

	wpec_slot_alu u_alu (
		.st       (st_rd),
		.oldest   (ring_q),
		.det      (mask_q[slot_q]),
		.len      (len_eff),
		.thr      (threshold_q),
		.slide    (slide_q),
		.nxt      (st_nxt),
		.ring_wr  (ring_wr),
		.ring_off (ring_off)
	);

	always_ff @(posedge clk) begin
		if (st_q == ST_RING)
			ring_q <= ring_mem[{idx, st_rd.head}];
		if ((st_q == ST_EXEC) && out_free && upd_q)
			ring_mem[{idx, ring_off}] <= ring_wr;
	end

	assign st_out = upd_q ? st_nxt : st_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			src_q       <= 4'd0;
			upd_q       <= 1'b0;
			mask_q      <= 8'd0;
			slot_q      <= 3'd0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (clear)
				seen_q <= '0;
			else if (in_xfer && src_ok)
				seen_q[s_tdata[3:0]] <= 1'b1;
			if ((st_q == ST_EXEC) && out_free)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_xfer && src_ok) begin
						src_q  <= s_tdata[3:0];
						mask_q <= s_tdata[11:4];
						upd_q  <= s_tuser || !seen_q[s_tdata[3:0]];
						slot_q <= 3'd0;
						if (n_eff != 4'd0)
							st_q <= ST_RD;
					end
				end
				ST_RD:   st_q <= ST_RING;
				ST_RING: st_q <= ST_EXEC;
				ST_EXEC: begin
					if (out_free) begin
						if (last) begin
							st_q <= ST_IDLE;
						end else begin
							slot_q <= slot_q + 3'd1;
							st_q   <= ST_RD;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((st_q == ST_EXEC) && out_free) begin
			out_data_q <= {7'd0, st_out.tal_trn, st_out.tal_alr, st_out.tal_abs,
				st_out.held, st_out.code, slot_q};
			out_last_q <= last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> ({1'b0, slot_q} < n_eff))
		else $error("slot counter beyond slot count");
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (({1'b0, m_tdata[2:0]} + 4'd1) == n_eff))
		else $error("last flag on wrong slot");
	a_bad_source: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !src_ok) |=> (st_q == ST_IDLE))
		else $error("out-of-range source started a frame");
`endif

endmodule
